// ----- src/assert_macros.svh -----
// assertion macros shared by the swarm engine modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds whenever not in reset
`define PSU_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication checked on the next cycle
`define PSU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/psu_pkg.sv -----
// shared types and constants of the swarm update engine
package psu_pkg;

    localparam int OP_BITS  = 3;
    localparam int FIT_BITS = 32;
    localparam int GAIN_BITS = 16;

    localparam logic [OP_BITS-1:0] OP_LOAD  = 3'd0;
    localparam logic [OP_BITS-1:0] OP_MOVE  = 3'd1;
    localparam logic [OP_BITS-1:0] OP_SCORE = 3'd2;
    localparam logic [OP_BITS-1:0] OP_END   = 3'd3;
    localparam logic [OP_BITS-1:0] OP_READ  = 3'd4;

    localparam logic [1:0] REG_INERTIA  = 2'd0;
    localparam logic [1:0] REG_PERSONAL = 2'd1;
    localparam logic [1:0] REG_GLOBAL   = 2'd2;

    localparam logic [GAIN_BITS-1:0] INERTIA_RESET  = 16'd45875;
    localparam logic [GAIN_BITS-1:0] PERSONAL_RESET = 16'd9830;
    localparam logic [GAIN_BITS-1:0] GLOBAL_RESET   = 16'd16384;

    localparam logic signed [FIT_BITS-1:0] FIT_MIN = {1'b1, {(FIT_BITS-1){1'b0}}};

    // decoded command class handed from front to back
    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_LOAD,
        CMD_MOVE,
        CMD_SCORE,
        CMD_END,
        CMD_READ
    } cmd_t;

endpackage

// ----- src/psu_front.sv -----
// front end: accepts items, classifies them and queues them for the back end
module psu_front
    import psu_pkg::*;
#(
    parameter int PARTICLES  = 16,
    parameter int DIMENSIONS = 6,
    parameter int COORD_BITS = 24,
    parameter int PIDX_BITS  = 4,
    parameter int DIDX_BITS  = 3
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [OP_BITS-1:0]           op,
    input  logic [3:0]                   particle,
    input  logic [2:0]                   dim,
    input  logic signed [COORD_BITS-1:0] pos_in,
    input  logic signed [COORD_BITS-1:0] speed_in,
    input  logic [GAIN_BITS-1:0]         rand_p,
    input  logic [GAIN_BITS-1:0]         rand_g,
    input  logic signed [FIT_BITS-1:0]   fitness,
    output logic                         q_valid,
    input  logic                         q_pop,
    output cmd_t                         q_cmd,
    output logic [PIDX_BITS-1:0]         q_particle,
    output logic [DIDX_BITS-1:0]         q_dim,
    output logic signed [COORD_BITS-1:0] q_pos,
    output logic signed [COORD_BITS-1:0] q_speed,
    output logic [GAIN_BITS-1:0]         q_rand_p,
    output logic [GAIN_BITS-1:0]         q_rand_g,
    output logic signed [FIT_BITS-1:0]   q_fitness
);

    localparam int DEPTH = 2;

    typedef struct packed {
        cmd_t                         cmd;
        logic [PIDX_BITS-1:0]         particle;
        logic [DIDX_BITS-1:0]         dim;
        logic signed [COORD_BITS-1:0] pos;
        logic signed [COORD_BITS-1:0] speed;
        logic [GAIN_BITS-1:0]         rand_p;
        logic [GAIN_BITS-1:0]         rand_g;
        logic signed [FIT_BITS-1:0]   fitness;
    } entry_t;

    entry_t     slot_reg [DEPTH];
    logic [0:0] wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    entry_t     in_entry;
    logic       p_ok, d_ok, push;

    assign p_ok = ({28'd0, particle} < 32'(PARTICLES));
    assign d_ok = ({29'd0, dim} < 32'(DIMENSIONS));

    always_comb
    begin
        in_entry.particle = particle[PIDX_BITS-1:0];
        in_entry.dim      = dim[DIDX_BITS-1:0];
        in_entry.pos      = pos_in;
        in_entry.speed    = speed_in;
        in_entry.rand_p   = rand_p;
        in_entry.rand_g   = rand_g;
        in_entry.fitness  = fitness;
        unique case (op)
            OP_LOAD:  in_entry.cmd = (p_ok && d_ok) ? CMD_LOAD : CMD_NOP;
            OP_MOVE:  in_entry.cmd = (p_ok && d_ok) ? CMD_MOVE : CMD_NOP;
            OP_SCORE: in_entry.cmd = p_ok ? CMD_SCORE : CMD_NOP;
            OP_END:   in_entry.cmd = CMD_END;
            OP_READ:  in_entry.cmd = d_ok ? CMD_READ : CMD_NOP;
            default:  in_entry.cmd = CMD_NOP;
        endcase
    end

    assign in_stall = (count_reg == 2'(DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != 2'd0);

    assign q_cmd      = slot_reg[rd_ptr_reg].cmd;
    assign q_particle = slot_reg[rd_ptr_reg].particle;
    assign q_dim      = slot_reg[rd_ptr_reg].dim;
    assign q_pos      = slot_reg[rd_ptr_reg].pos;
    assign q_speed    = slot_reg[rd_ptr_reg].speed;
    assign q_rand_p   = slot_reg[rd_ptr_reg].rand_p;
    assign q_rand_g   = slot_reg[rd_ptr_reg].rand_g;
    assign q_fitness  = slot_reg[rd_ptr_reg].fitness;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(q_pop);
        end
    end

    `include "assert_macros.svh"
    `PSU_ASSERT(a_no_pop_empty, clk, rst_n, (q_pop |-> q_valid), "pop from empty queue")
    `PSU_ASSERT(a_count_range, clk, rst_n, (count_reg <= 2'(DEPTH)), "queue count overflow")
    `PSU_ASSERT_NEXT(a_push_fills, clk, rst_n, push && !q_pop, count_reg == $past(count_reg) + 2'd1, "push lost")

endmodule

// ----- src/psu_back.sv -----
// back end: executes queued commands against the swarm stores and registers the result
module psu_back
    import psu_pkg::*;
#(
    parameter int PARTICLES  = 16,
    parameter int DIMENSIONS = 6,
    parameter int COORD_BITS = 24,
    parameter int PIDX_BITS  = 4,
    parameter int DIDX_BITS  = 3
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [GAIN_BITS-1:0]         inertia_gain,
    input  logic [GAIN_BITS-1:0]         personal_gain,
    input  logic [GAIN_BITS-1:0]         global_gain,
    input  logic                         q_valid,
    output logic                         q_pop,
    input  cmd_t                         q_cmd,
    input  logic [PIDX_BITS-1:0]         q_particle,
    input  logic [DIDX_BITS-1:0]         q_dim,
    input  logic signed [COORD_BITS-1:0] q_pos,
    input  logic signed [COORD_BITS-1:0] q_speed,
    input  logic [GAIN_BITS-1:0]         q_rand_p,
    input  logic [GAIN_BITS-1:0]         q_rand_g,
    input  logic signed [FIT_BITS-1:0]   q_fitness,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [COORD_BITS-1:0] position_out,
    output logic signed [COORD_BITS-1:0] speed_out,
    output logic                         improved,
    output logic signed [FIT_BITS-1:0]   global_fitness,
    output logic signed [FIT_BITS-1:0]   best_fitness,
    output logic signed [COORD_BITS-1:0] global_component,
    output logic signed [COORD_BITS-1:0] best_component
);

    localparam int CELLS     = PARTICLES * DIMENSIONS;
    localparam int CIDX_BITS = $clog2(CELLS);
    localparam int DCNT_BITS = $clog2(DIMENSIONS + 1);
    localparam int CW        = COORD_BITS;
    localparam int DW        = COORD_BITS + 1;
    localparam int PW        = COORD_BITS + 18;
    localparam int SW        = COORD_BITS + 20;
    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_MV_COEF,
        ST_MV_MUL,
        ST_MV_SUM,
        ST_MV_WR,
        ST_SC_DEC,
        ST_SC_COPY,
        ST_END_COPY,
        ST_END_ABS,
        ST_OUT
    } state_t;

    // cell memories, one write and one read port each
    logic signed [CW-1:0] pos_mem   [CELLS];
    logic signed [CW-1:0] speed_mem [CELLS];
    logic signed [CW-1:0] pb_mem    [CELLS];
    logic signed [FIT_BITS-1:0] pbfit_mem [PARTICLES];

    logic [PARTICLES-1:0] pb_valid_reg;
    logic signed [CW-1:0] gbest_reg [DIMENSIONS];
    logic signed [CW-1:0] abs_reg   [DIMENSIONS];
    logic signed [FIT_BITS-1:0] gfit_reg, afit_reg, cfit_reg;
    logic [PIDX_BITS-1:0] cpart_reg;
    logic                 cvalid_reg;

    state_t state_reg;
    cmd_t   cmd_reg;
    logic [PIDX_BITS-1:0] part_reg;
    logic [DIDX_BITS-1:0] dim_reg;
    logic signed [CW-1:0] qpos_reg, qspeed_reg;
    logic [GAIN_BITS-1:0] rp_reg, rg_reg;
    logic signed [FIT_BITS-1:0] fit_reg;
    logic [CIDX_BITS-1:0] base_reg;
    logic [DCNT_BITS-1:0] k_reg;

    logic signed [CW-1:0] x_rd_reg, v_rd_reg, pb_rd_reg;
    logic signed [FIT_BITS-1:0] pbfit_rd_reg;
    logic [GAIN_BITS-1:0] cp_reg, cg_reg;
    logic signed [PW-1:0] t0_reg, t1_reg, t2_reg;
    logic signed [CW-1:0] vnew_reg;

    logic                 rd_en, wr_pos, wr_speed, wr_pb, wr_pbfit;
    logic [CIDX_BITS-1:0] rd_addr, wr_addr;
    logic signed [CW-1:0] wr_pos_d, wr_speed_d, wr_pb_d;

    logic [2*GAIN_BITS-1:0] cp_full, cg_full;
    logic signed [DW-1:0]   dp, dg;
    logic signed [SW-1:0]   sum, rnd;
    logic signed [SW-17:0]  vsh;
    logic signed [CW-1:0]   vsat, xsat;
    logic signed [CW:0]     xsum;
    logic [DIDX_BITS-1:0]   kd;

    assign kd      = k_reg[DIDX_BITS-1:0];
    // take the next command only once the result register is free
    assign q_pop   = (state_reg == ST_IDLE) && q_valid && (!out_valid || !out_stall);

    function automatic logic [CIDX_BITS-1:0] cell_base(input logic [PIDX_BITS-1:0] p);
        logic [CIDX_BITS+PIDX_BITS-1:0] prod;
        begin
            prod = (CIDX_BITS+PIDX_BITS)'(p) * (CIDX_BITS+PIDX_BITS)'(DIMENSIONS);
            return prod[CIDX_BITS-1:0];
        end
    endfunction

    // memory address and write selection
    always_comb
    begin
        rd_en      = 1'b0;
        rd_addr    = base_reg + CIDX_BITS'(dim_reg);
        wr_pos     = 1'b0;
        wr_speed   = 1'b0;
        wr_pb      = 1'b0;
        wr_pbfit   = 1'b0;
        wr_addr    = base_reg + CIDX_BITS'(dim_reg);
        wr_pos_d   = qpos_reg;
        wr_speed_d = qspeed_reg;
        wr_pb_d    = qpos_reg;
        case (state_reg)
            ST_RD:
            begin
                rd_en = 1'b1;
                if (cmd_reg == CMD_LOAD)
                begin
                    wr_pos   = 1'b1;
                    wr_speed = 1'b1;
                    wr_pb    = 1'b1;
                end
                if (cmd_reg == CMD_SCORE || cmd_reg == CMD_END)
                begin
                    rd_addr = base_reg;
                end
            end
            ST_MV_WR:
            begin
                wr_pos     = 1'b1;
                wr_speed   = 1'b1;
                wr_pos_d   = xsat;
                wr_speed_d = vnew_reg;
            end
            ST_SC_COPY, ST_END_COPY:
            begin
                rd_en   = 1'b1;
                rd_addr = base_reg + CIDX_BITS'(k_reg) + CIDX_BITS'(1);
                if (state_reg == ST_SC_COPY)
                begin
                    wr_pb    = 1'b1;
                    wr_pb_d  = x_rd_reg;
                    wr_addr  = base_reg + CIDX_BITS'(k_reg);
                    wr_pbfit = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_pos)
        begin
            pos_mem[wr_addr] <= wr_pos_d;
        end
        if (wr_speed)
        begin
            speed_mem[wr_addr] <= wr_speed_d;
        end
        if (wr_pb)
        begin
            pb_mem[wr_addr] <= wr_pb_d;
        end
        if (wr_pbfit)
        begin
            pbfit_mem[part_reg] <= fit_reg;
        end
        if (rd_en)
        begin
            x_rd_reg  <= pos_mem[rd_addr];
            v_rd_reg  <= speed_mem[rd_addr];
            pb_rd_reg <= pb_mem[rd_addr];
        end
        pbfit_rd_reg <= pbfit_mem[part_reg];
    end

    // move datapath
    assign cp_full = personal_gain * rp_reg + 32'd32768;
    assign cg_full = global_gain * rg_reg + 32'd32768;
    assign dp      = DW'(pb_rd_reg) - DW'(x_rd_reg);
    assign dg      = DW'(gbest_reg[dim_reg]) - DW'(x_rd_reg);
    assign sum     = SW'(t0_reg) + SW'(t1_reg) + SW'(t2_reg);
    assign rnd     = sum + SW'(32768);
    assign vsh     = rnd[SW-1:16];
    assign vsat    = (vsh > (SW-16)'(CMAX)) ? CMAX :
                     (vsh < (SW-16)'(CMIN)) ? CMIN : vsh[CW-1:0];
    assign xsum    = (CW+1)'(x_rd_reg) + (CW+1)'(vnew_reg);
    assign xsat    = (xsum[CW] != xsum[CW-1]) ? (xsum[CW] ? CMIN : CMAX) : xsum[CW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            out_valid    <= 1'b0;
            pb_valid_reg <= '0;
            gfit_reg     <= FIT_MIN;
            afit_reg     <= FIT_MIN;
            cfit_reg     <= FIT_MIN;
            cpart_reg    <= '0;
            cvalid_reg   <= 1'b0;
            for (int i = 0; i < DIMENSIONS; i++)
            begin
                gbest_reg[i] <= '0;
                abs_reg[i]   <= '0;
            end
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_pop)
                    begin
                        cmd_reg    <= q_cmd;
                        part_reg   <= q_particle;
                        dim_reg    <= q_dim;
                        qpos_reg   <= q_pos;
                        qspeed_reg <= q_speed;
                        rp_reg     <= q_rand_p;
                        rg_reg     <= q_rand_g;
                        fit_reg    <= q_fitness;
                        base_reg   <= cell_base((q_cmd == CMD_END) ? cpart_reg : q_particle);
                        k_reg      <= '0;
                        state_reg  <= ST_RD;
                    end
                end
                ST_RD:
                begin
                    position_out     <= '0;
                    speed_out        <= '0;
                    global_component <= '0;
                    best_component   <= '0;
                    improved         <= 1'b0;
                    state_reg        <= ST_OUT;
                    case (cmd_reg)
                        CMD_LOAD:  pb_valid_reg[part_reg] <= 1'b0;
                        CMD_MOVE:  state_reg <= ST_MV_COEF;
                        CMD_SCORE: state_reg <= ST_SC_DEC;
                        CMD_END:
                        begin
                            if (cvalid_reg)
                            begin
                                state_reg <= ST_END_COPY;
                            end
                            else
                            begin
                                cvalid_reg <= 1'b0;
                                cfit_reg   <= FIT_MIN;
                                cpart_reg  <= '0;
                            end
                        end
                        CMD_READ:
                        begin
                            global_component <= gbest_reg[dim_reg];
                            best_component   <= abs_reg[dim_reg];
                        end
                        default:
                        begin
                        end
                    endcase
                end
                ST_MV_COEF:
                begin
                    cp_reg    <= cp_full[2*GAIN_BITS-1:GAIN_BITS];
                    cg_reg    <= cg_full[2*GAIN_BITS-1:GAIN_BITS];
                    state_reg <= ST_MV_MUL;
                end
                ST_MV_MUL:
                begin
                    t0_reg    <= PW'($signed({1'b0, inertia_gain}) * v_rd_reg);
                    t1_reg    <= PW'($signed({1'b0, cp_reg}) * dp);
                    t2_reg    <= PW'($signed({1'b0, cg_reg}) * dg);
                    state_reg <= ST_MV_SUM;
                end
                ST_MV_SUM:
                begin
                    vnew_reg  <= vsat;
                    state_reg <= ST_MV_WR;
                end
                ST_MV_WR:
                begin
                    position_out <= xsat;
                    speed_out    <= vnew_reg;
                    state_reg    <= ST_OUT;
                end
                ST_SC_DEC:
                begin
                    if (!pb_valid_reg[part_reg] || fit_reg > pbfit_rd_reg)
                    begin
                        improved               <= 1'b1;
                        pb_valid_reg[part_reg] <= 1'b1;
                        state_reg              <= ST_SC_COPY;
                    end
                    else
                    begin
                        state_reg <= ST_OUT;
                    end
                    if (!cvalid_reg || fit_reg > cfit_reg)
                    begin
                        cvalid_reg <= 1'b1;
                        cfit_reg   <= fit_reg;
                        cpart_reg  <= part_reg;
                    end
                end
                ST_SC_COPY:
                begin
                    k_reg <= k_reg + DCNT_BITS'(1);
                    if (k_reg == DCNT_BITS'(DIMENSIONS - 1))
                    begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_END_COPY:
                begin
                    gbest_reg[kd] <= x_rd_reg;
                    k_reg         <= k_reg + DCNT_BITS'(1);
                    if (k_reg == DCNT_BITS'(DIMENSIONS - 1))
                    begin
                        state_reg <= ST_END_ABS;
                    end
                end
                ST_END_ABS:
                begin
                    gfit_reg <= cfit_reg;
                    if (cfit_reg > afit_reg)
                    begin
                        afit_reg <= cfit_reg;
                        for (int i = 0; i < DIMENSIONS; i++)
                        begin
                            abs_reg[i] <= gbest_reg[i];
                        end
                    end
                    cvalid_reg <= 1'b0;
                    cfit_reg   <= FIT_MIN;
                    cpart_reg  <= '0;
                    state_reg  <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (!out_valid || !out_stall)
                    begin
                        out_valid      <= 1'b1;
                        global_fitness <= gfit_reg;
                        best_fitness   <= afit_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
            if (out_valid && !out_stall && state_reg != ST_OUT)
            begin
                out_valid <= 1'b0;
            end
        end
    end

    `include "assert_macros.svh"
    `PSU_ASSERT(a_pop_idle, clk, rst_n, (q_pop |-> state_reg == ST_IDLE), "pop while busy")
    `PSU_ASSERT_NEXT(a_end_clears, clk, rst_n, state_reg == ST_END_ABS, !cvalid_reg, "candidate kept after end")
    `PSU_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(global_fitness), "stalled result changed")

endmodule

// ----- src/psu_cfg.sv -----
// gain register file written through the configuration channel
module psu_cfg
    import psu_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [GAIN_BITS-1:0] cfg_data,
    output logic [GAIN_BITS-1:0] inertia_gain,
    output logic [GAIN_BITS-1:0] personal_gain,
    output logic [GAIN_BITS-1:0] global_gain
);

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inertia_gain  <= INERTIA_RESET;
            personal_gain <= PERSONAL_RESET;
            global_gain   <= GLOBAL_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_INERTIA:  inertia_gain  <= cfg_data;
                REG_PERSONAL: personal_gain <= cfg_data;
                REG_GLOBAL:   global_gain   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

endmodule

// ----- src/particle_swarm_update_engine.sv -----
// particle swarm update engine: global-best swarm with per-dimension update
// usage:
//   input channel in_valid/in_stall carries one op per transaction (load, move,
//   score, end, read); every accepted transaction yields exactly one result
//   transaction on out_valid/out_stall.
//   configuration channel cfg_valid/cfg_ready writes gain registers 0..2;
//   it is always ready, write only while the engine is idle.
//   a two-entry queue separates the decoding front end from the executing
//   back end, so the input is taken while a result waits on a stalled output.
//   each op starts with a read state; load/read/unknown then go to output,
//   move runs coefficient, multiply, sum and write states, score a decision
//   and, if the personal best improves, a row copy, and end a row copy and
//   best update if a candidate exists; a new item is popped only once the last
//   result is issued. row copies of score and end go one dimension per cycle.
//   reset clears the queue, valid flags, best fitnesses and best rows;
//   position, speed and personal-best stores are undefined until loaded.
//   a stalled result holds its value until taken; the queue then fills and
//   in_stall rises.
module particle_swarm_update_engine
    import psu_pkg::*;
#(
    parameter int PARTICLES  = 16,
    parameter int DIMENSIONS = 6,
    parameter int COORD_BITS = 24
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [OP_BITS-1:0]           op,
    input  logic [3:0]                   particle,
    input  logic [2:0]                   dim,
    input  logic signed [COORD_BITS-1:0] pos_in,
    input  logic signed [COORD_BITS-1:0] speed_in,
    input  logic [GAIN_BITS-1:0]         rand_p,
    input  logic [GAIN_BITS-1:0]         rand_g,
    input  logic signed [FIT_BITS-1:0]   fitness,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [1:0]                   cfg_index,
    input  logic [GAIN_BITS-1:0]         cfg_data,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [COORD_BITS-1:0] position_out,
    output logic signed [COORD_BITS-1:0] speed_out,
    output logic                         improved,
    output logic signed [FIT_BITS-1:0]   global_fitness,
    output logic signed [FIT_BITS-1:0]   best_fitness,
    output logic signed [COORD_BITS-1:0] global_component,
    output logic signed [COORD_BITS-1:0] best_component
);

    localparam int PIDX_BITS = (PARTICLES > 16) ? 4 : $clog2(PARTICLES);
    localparam int DIDX_BITS = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;

    logic [GAIN_BITS-1:0] inertia_gain, personal_gain, global_gain;
    logic                 q_valid, q_pop;
    cmd_t                 q_cmd;
    logic [PIDX_BITS-1:0] q_particle;
    logic [DIDX_BITS-1:0] q_dim;
    logic signed [COORD_BITS-1:0] q_pos, q_speed;
    logic [GAIN_BITS-1:0] q_rand_p, q_rand_g;
    logic signed [FIT_BITS-1:0] q_fitness;

    psu_cfg u_cfg (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .inertia_gain(inertia_gain), .personal_gain(personal_gain),
        .global_gain(global_gain)
    );

    psu_front #(
        .PARTICLES(PARTICLES), .DIMENSIONS(DIMENSIONS), .COORD_BITS(COORD_BITS),
        .PIDX_BITS(PIDX_BITS), .DIDX_BITS(DIDX_BITS)
    ) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .particle(particle), .dim(dim),
        .pos_in(pos_in), .speed_in(speed_in),
        .rand_p(rand_p), .rand_g(rand_g), .fitness(fitness),
        .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd),
        .q_particle(q_particle), .q_dim(q_dim), .q_pos(q_pos), .q_speed(q_speed),
        .q_rand_p(q_rand_p), .q_rand_g(q_rand_g), .q_fitness(q_fitness)
    );

    psu_back #(
        .PARTICLES(PARTICLES), .DIMENSIONS(DIMENSIONS), .COORD_BITS(COORD_BITS),
        .PIDX_BITS(PIDX_BITS), .DIDX_BITS(DIDX_BITS)
    ) u_back (
        .clk(clk), .rst_n(rst_n),
        .inertia_gain(inertia_gain), .personal_gain(personal_gain),
        .global_gain(global_gain),
        .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd),
        .q_particle(q_particle), .q_dim(q_dim), .q_pos(q_pos), .q_speed(q_speed),
        .q_rand_p(q_rand_p), .q_rand_g(q_rand_g), .q_fitness(q_fitness),
        .out_valid(out_valid), .out_stall(out_stall),
        .position_out(position_out), .speed_out(speed_out), .improved(improved),
        .global_fitness(global_fitness), .best_fitness(best_fitness),
        .global_component(global_component), .best_component(best_component)
    );

endmodule

// ----- tb/particle_swarm_update_engine_tb.sv -----
// self-checking testbench for the particle swarm update engine
`timescale 1ns / 100ps

module particle_swarm_update_engine_tb;
    import psu_pkg::*;

    localparam int NPART = 16;
    localparam int NDIM = 6;
    localparam int CW = 24;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [1:0] REG_SPARE = 2'd3;
    localparam logic [OP_BITS-1:0] OP_SPARE_LO = 3'd5;
    localparam logic [OP_BITS-1:0] OP_SPARE_HI = 3'd7;
    localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [FIT_BITS-1:0] FIT_MAX = {1'b0, {(FIT_BITS-1){1'b1}}};

    typedef struct {
        logic [OP_BITS-1:0]         op;
        logic [3:0]                 particle;
        logic [2:0]                 dim;
        logic signed [CW-1:0]       pos;
        logic signed [CW-1:0]       speed;
        logic [GAIN_BITS-1:0]       rp;
        logic [GAIN_BITS-1:0]       rg;
        logic signed [FIT_BITS-1:0] fit;
    } swarm_cmd_t;

    typedef struct {
        logic signed [CW-1:0]       position;
        logic signed [CW-1:0]       speed;
        logic                       improved;
        logic signed [FIT_BITS-1:0] gfit;
        logic signed [FIT_BITS-1:0] bfit;
        logic signed [CW-1:0]       gcomp;
        logic signed [CW-1:0]       bcomp;
    } swarm_result_t;

    class swarm_scoreboard;
        longint omega, phi_p, phi_g;
        longint pos_row[NPART*NDIM];
        longint spd_row[NPART*NDIM];
        longint pbest_row[NPART*NDIM];
        longint pbest_fit[NPART];
        bit     pbest_ok[NPART];
        longint gbest_row[NDIM];
        longint abs_row[NDIM];
        longint gbest_fit, abs_fit, cand_fit;
        int     cand_part;
        bit     cand_ok;
        swarm_result_t pending_results[$];
        int errors, checked;
        int op_count[8];

        function new();
            omega = INERTIA_RESET;
            phi_p = PERSONAL_RESET;
            phi_g = GLOBAL_RESET;
            foreach (pbest_ok[i]) pbest_ok[i] = 0;
            foreach (gbest_row[i]) begin
                gbest_row[i] = 0;
                abs_row[i] = 0;
            end
            gbest_fit = FIT_MIN;
            abs_fit = FIT_MIN;
            cand_fit = FIT_MIN;
            cand_part = 0;
            cand_ok = 0;
            errors = 0;
            checked = 0;
        endfunction

        function void set_gain(logic [1:0] idx, logic [GAIN_BITS-1:0] val);
            if (idx == REG_INERTIA) omega = val;
            else if (idx == REG_PERSONAL) phi_p = val;
            else if (idx == REG_GLOBAL) phi_g = val;
        endfunction

        function longint clamp_coord(longint v);
            longint hi, lo;
            hi = (longint'(1) << (CW-1)) - 1;
            lo = -hi - 1;
            return v > hi ? hi : (v < lo ? lo : v);
        endfunction

        // run one command through the swarm state and queue the result it must give
        function void note_command(swarm_cmd_t c);
            swarm_result_t r;
            int cix, base;
            longint x, cp, cg, acc, v, fit;
            r = '{default: '0};
            cix = c.particle * NDIM + c.dim;
            base = c.particle * NDIM;
            fit = c.fit;
            op_count[c.op]++;
            if (c.op == OP_LOAD && c.dim < NDIM) begin
                pos_row[cix] = c.pos;
                spd_row[cix] = c.speed;
                pbest_row[cix] = c.pos;
                pbest_ok[c.particle] = 0;
            end else if (c.op == OP_MOVE && c.dim < NDIM) begin
                x = pos_row[cix];
                cp = (phi_p * longint'(c.rp) + 32768) >>> 16;
                cg = (phi_g * longint'(c.rg) + 32768) >>> 16;
                acc = omega * spd_row[cix] + cp * (pbest_row[cix] - x)
                    + cg * (gbest_row[c.dim] - x);
                v = clamp_coord((acc + 32768) >>> 16);
                x = clamp_coord(x + v);
                spd_row[cix] = v;
                pos_row[cix] = x;
                r.position = x;
                r.speed = v;
            end else if (c.op == OP_SCORE) begin
                if (!pbest_ok[c.particle] || fit > pbest_fit[c.particle]) begin
                    pbest_ok[c.particle] = 1;
                    pbest_fit[c.particle] = fit;
                    for (int k = 0; k < NDIM; k++) pbest_row[base+k] = pos_row[base+k];
                    r.improved = 1;
                end
                if (!cand_ok || fit > cand_fit) begin
                    cand_ok = 1;
                    cand_fit = fit;
                    cand_part = c.particle;
                end
            end else if (c.op == OP_END) begin
                if (cand_ok) begin
                    for (int k = 0; k < NDIM; k++) gbest_row[k] = pos_row[cand_part*NDIM+k];
                    gbest_fit = cand_fit;
                    if (cand_fit > abs_fit) begin
                        abs_fit = cand_fit;
                        abs_row = gbest_row;
                    end
                end
                cand_ok = 0;
                cand_fit = FIT_MIN;
                cand_part = 0;
            end else if (c.op == OP_READ && c.dim < NDIM) begin
                r.gcomp = gbest_row[c.dim];
                r.bcomp = abs_row[c.dim];
            end
            r.gfit = gbest_fit;
            r.bfit = abs_fit;
            pending_results.push_back(r);
        endfunction

        function void check_result(swarm_result_t got);
            swarm_result_t exp;
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing pending", $realtime);
                errors++;
                return;
            end
            exp = pending_results.pop_front();
            checked++;
            if (got.position !== exp.position) begin
                $display("%0t: position_out exp %0d got %0d", $realtime, exp.position, got.position);
                errors++;
            end
            if (got.speed !== exp.speed) begin
                $display("%0t: speed_out exp %0d got %0d", $realtime, exp.speed, got.speed);
                errors++;
            end
            if (got.improved !== exp.improved) begin
                $display("%0t: improved exp %0d got %0d", $realtime, exp.improved, got.improved);
                errors++;
            end
            if (got.gfit !== exp.gfit) begin
                $display("%0t: global_fitness exp %0d got %0d", $realtime, exp.gfit, got.gfit);
                errors++;
            end
            if (got.bfit !== exp.bfit) begin
                $display("%0t: best_fitness exp %0d got %0d", $realtime, exp.bfit, got.bfit);
                errors++;
            end
            if (got.gcomp !== exp.gcomp) begin
                $display("%0t: global_component exp %0d got %0d", $realtime, exp.gcomp, got.gcomp);
                errors++;
            end
            if (got.bcomp !== exp.bcomp) begin
                $display("%0t: best_component exp %0d got %0d", $realtime, exp.bcomp, got.bcomp);
                errors++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_stall;
    logic [OP_BITS-1:0] op = '0;
    logic [3:0] particle = '0;
    logic [2:0] dim = '0;
    logic signed [CW-1:0] pos_in = '0;
    logic signed [CW-1:0] speed_in = '0;
    logic [GAIN_BITS-1:0] rand_p = '0;
    logic [GAIN_BITS-1:0] rand_g = '0;
    logic signed [FIT_BITS-1:0] fitness = '0;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [GAIN_BITS-1:0] cfg_data = '0;
    logic out_valid;
    logic out_stall = 0;
    logic signed [CW-1:0] position_out, speed_out, global_component, best_component;
    logic improved;
    logic signed [FIT_BITS-1:0] global_fitness, best_fitness;

    swarm_scoreboard sb = new();
    bit quiet = 0;
    int cycles = 0;

    particle_swarm_update_engine DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .particle(particle), .dim(dim), .pos_in(pos_in), .speed_in(speed_in),
        .rand_p(rand_p), .rand_g(rand_g), .fitness(fitness),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .out_valid(out_valid), .out_stall(out_stall),
        .position_out(position_out), .speed_out(speed_out), .improved(improved),
        .global_fitness(global_fitness), .best_fitness(best_fitness),
        .global_component(global_component), .best_component(best_component)
    );

    always
    begin
        #6 clk = 1;
        #6 clk = 0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result('{position_out, speed_out, improved, global_fitness,
                              best_fitness, global_component, best_component});
    end

    function automatic int draw_gap();
        if (quiet || $urandom_range(0, 3) == 0) return 0;
        return $urandom_range(0, 6);
    endfunction

    // receiver: stall for a random count before each result transaction
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            n = draw_gap();
            if (n > 0)
            begin
                out_stall <= 1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 0;
            do @(posedge clk); while (!(out_valid && !out_stall));
        end
    end

    task automatic send_cmd(swarm_cmd_t c);
        int n;
        in_valid <= 1;
        op <= c.op;
        particle <= c.particle;
        dim <= c.dim;
        pos_in <= c.pos;
        speed_in <= c.speed;
        rand_p <= c.rp;
        rand_g <= c.rg;
        fitness <= c.fit;
        do @(posedge clk); while (in_stall);
        sb.note_command(c);
        n = draw_gap();
        if (n > 0)
        begin
            in_valid <= 0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic write_gain(logic [1:0] idx, logic [GAIN_BITS-1:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        sb.set_gain(idx, val);
        cfg_valid <= 0;
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (sb.pending_results.size() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    function automatic swarm_cmd_t make_cmd(logic [OP_BITS-1:0] o, int p, int d,
                                            longint f = 0);
        swarm_cmd_t c;
        c.op = o;
        c.particle = p;
        c.dim = d;
        c.pos = $urandom;
        c.speed = $urandom;
        c.rp = $urandom;
        c.rg = $urandom;
        c.fit = f;
        return c;
    endfunction

    function automatic swarm_cmd_t random_cmd();
        swarm_cmd_t c;
        int w;
        w = $urandom_range(0, 99);
        c = make_cmd(OP_MOVE, $urandom_range(0, NPART-1), $urandom_range(0, NDIM-1));
        if (w < 8) c.op = OP_LOAD;
        else if (w < 45) c.op = OP_MOVE;
        else if (w < 70) c.op = OP_SCORE;
        else if (w < 80) c.op = OP_END;
        else if (w < 95) c.op = OP_READ;
        else c.op = $urandom_range(OP_SPARE_LO, OP_SPARE_HI);
        if ($urandom_range(0, 15) == 0) c.dim = $urandom_range(NDIM, 7);
        c.fit = $urandom;
        if ($urandom_range(0, 3) == 0) c.fit = $signed(c.fit) >>> 20;
        if ($urandom_range(0, 4) == 0) c.pos = $signed(c.pos) >>> 8;
        return c;
    endfunction

    task automatic run_random(int count);
        for (int i = 0; i < count; i++) send_cmd(random_cmd());
    endtask

    initial
    begin
        swarm_cmd_t c;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // fill every cell first so no move or row copy ever sees an unwritten entry
        for (int p = 0; p < NPART; p++)
            for (int d = 0; d < NDIM; d++)
                send_cmd(make_cmd(OP_LOAD, p, d));

        // extremes and corner cases
        c = make_cmd(OP_LOAD, 3, 0); c.pos = COORD_MAX; c.speed = COORD_MAX; send_cmd(c);
        c = make_cmd(OP_MOVE, 3, 0); c.rp = '1; c.rg = '1; send_cmd(c);
        c = make_cmd(OP_LOAD, 4, 1); c.pos = COORD_MIN; c.speed = COORD_MIN; send_cmd(c);
        c = make_cmd(OP_MOVE, 4, 1); c.rp = '0; c.rg = '0; send_cmd(c);
        send_cmd(make_cmd(OP_END, 0, 0));
        send_cmd(make_cmd(OP_SCORE, 3, 0, FIT_MIN));
        send_cmd(make_cmd(OP_SCORE, 3, 0, FIT_MIN));
        send_cmd(make_cmd(OP_SCORE, 4, 0, FIT_MIN));
        send_cmd(make_cmd(OP_SCORE, 4, 0, 100));
        send_cmd(make_cmd(OP_END, 0, 7));
        send_cmd(make_cmd(OP_READ, 0, 0));
        send_cmd(make_cmd(OP_READ, 0, 7));
        send_cmd(make_cmd(OP_SCORE, 5, 2, FIT_MAX));
        send_cmd(make_cmd(OP_SCORE, 6, 2, FIT_MAX));
        send_cmd(make_cmd(OP_END, 0, 0));
        send_cmd(make_cmd(OP_READ, 0, 1));
        send_cmd(make_cmd(OP_MOVE, 5, 2));
        send_cmd(make_cmd(OP_MOVE, 5, 6));
        send_cmd(make_cmd(OP_LOAD, 5, 7));
        send_cmd(make_cmd(OP_SCORE, 7, 0, -5));
        send_cmd(make_cmd(OP_END, 0, 0));
        send_cmd(make_cmd(OP_SPARE_LO, 1, 1));
        send_cmd(make_cmd(OP_SPARE_HI, 15, 5));
        drain();

        // gain settings: reset values, all ones, all zeros, random
        run_random(130);
        drain();
        write_gain(REG_INERTIA, '1);
        write_gain(REG_PERSONAL, '1);
        write_gain(REG_GLOBAL, '1);
        quiet = 1;
        run_random(130);
        drain();
        quiet = 0;
        write_gain(REG_INERTIA, '0);
        write_gain(REG_PERSONAL, '0);
        write_gain(REG_GLOBAL, '0);
        run_random(130);
        drain();
        write_gain(REG_SPARE, $urandom);
        write_gain(REG_INERTIA, $urandom);
        write_gain(REG_PERSONAL, $urandom);
        write_gain(REG_GLOBAL, $urandom);
        run_random(160);
        drain();

        $display("covered %0d loads, %0d moves, %0d scores, %0d ends, %0d reads",
                 sb.op_count[OP_LOAD], sb.op_count[OP_MOVE], sb.op_count[OP_SCORE],
                 sb.op_count[OP_END], sb.op_count[OP_READ]);
        $display("%0d results compared over four gain settings", sb.checked);
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
